@@ src/kce_pkg.sv @@
`default_nettype none

package kce_pkg;

  localparam int unsigned ScanW   = 32;
  localparam int unsigned MaxKeys = 7;
  localparam int unsigned KeyIdxW = 3;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgKeyCount = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKeyMask0 = 3'd1;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StLast = 3'b100
  } state_e;

  typedef struct packed {
    logic [KeyIdxW-1:0] key_index;
    logic               pressed;
  } event_t;

endpackage

`default_nettype wire

@@ src/key_change_event_emitter_top.sv @@
// Operation: a word is taken in the idle state, then the scan state visits each configured key
//   in turn plus one end-of-scan step, and a closing state hands over the last event; an
//   output stall can hold both the scan and the closing state.
// The input stalls until the scan of a word is through; the single mask compare unit sets this.
// Events leave through an output register, one per cycle at most.
// Reset (rst_ni low, asynchronous): previous scan word, key count and masks clear to zero.
`default_nettype none

module key_change_event_emitter_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [kce_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [kce_pkg::ScanW-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [kce_pkg::ScanW-1:0]         scan_word_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [kce_pkg::KeyIdxW-1:0]       key_index_o,
  output      logic                              pressed_o,
  output      logic                              final_event_o
);

  kce_pkg::state_e             state_q, state_d;
  logic [kce_pkg::KeyIdxW-1:0] key_count_q;
  logic [kce_pkg::ScanW-1:0]   mask_q [kce_pkg::MaxKeys];
  logic [kce_pkg::ScanW-1:0]   prev_q;
  logic [kce_pkg::ScanW-1:0]   scan_q;
  logic [kce_pkg::ScanW-1:0]   diff_q;
  logic [kce_pkg::KeyIdxW-1:0] key_q, key_d;
  logic                        pend_valid_q, pend_valid_d;
  kce_pkg::event_t             pend_q, pend_d;
  logic                        out_valid_q, out_valid_d;
  kce_pkg::event_t             out_q;
  logic                        out_final_q;

  logic                        in_accept;
  logic                        can_push;
  logic                        push;
  logic                        push_final;
  logic [kce_pkg::ScanW-1:0]   mask_sel;
  logic                        hit;
  logic                        now_set;
  logic [kce_pkg::CfgIdxW-1:0] mask_wr_idx;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != kce_pkg::StIdle);
  assign can_push    = !out_valid_q || !out_stall_i;
  assign mask_wr_idx = cfg_idx_i - kce_pkg::CfgKeyMask0;

  // Shared compare unit: one key mask a cycle, unless an output stall holds the scan
  assign mask_sel = (key_q < kce_pkg::KeyIdxW'(kce_pkg::MaxKeys)) ? mask_q[key_q] : '0;
  assign hit      = |(diff_q & mask_sel);
  assign now_set  = |(scan_q & mask_sel);

  always_comb begin
    state_d      = state_q;
    key_d        = key_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    push         = 1'b0;
    push_final   = 1'b0;
    case (state_q)
      kce_pkg::StIdle: begin
        if (in_accept) begin
          state_d      = kce_pkg::StScan;
          key_d        = '0;
          pend_valid_d = 1'b0;
        end
      end
      kce_pkg::StScan: begin
        if (key_q == key_count_q) begin
          state_d = kce_pkg::StLast;
        end else if (!(hit && pend_valid_q && !can_push)) begin
          key_d = key_q + 1'b1;
          if (hit) begin
            // a newer hit exists, so the held event is not the last one
            push           = pend_valid_q;
            pend_valid_d   = 1'b1;
            pend_d.key_index = key_q;
            pend_d.pressed   = now_set;
          end
        end
      end
      kce_pkg::StLast: begin
        if (!pend_valid_q) begin
          state_d = kce_pkg::StIdle;
        end else if (can_push) begin
          push         = 1'b1;
          push_final   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = kce_pkg::StIdle;
        end
      end
      default: begin
        state_d = kce_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_d = push || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kce_pkg::StIdle;
      key_count_q  <= '0;
      for (int i = 0; i < kce_pkg::MaxKeys; i++) begin
        mask_q[i] <= '0;
      end
      prev_q       <= '0;
      key_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      key_q        <= key_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == kce_pkg::CfgKeyCount) begin
          key_count_q <= cfg_data_i[kce_pkg::KeyIdxW-1:0];
        end else begin
          mask_q[mask_wr_idx] <= cfg_data_i;
        end
      end
      if (in_accept) begin
        prev_q <= scan_word_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (in_accept) begin
      scan_q <= scan_word_i;
      diff_q <= scan_word_i ^ prev_q;
    end
    if (push) begin
      out_q       <= pend_q;
      out_final_q <= push_final;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign key_index_o   = out_q.key_index;
  assign pressed_o     = out_q.pressed;
  assign final_event_o = out_final_q;

endmodule

`default_nettype wire

@@ src/kce_checker.sv @@
`default_nettype none

module kce_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [kce_pkg::KeyIdxW-1:0] key_index_o,
  input wire logic                        pressed_o,
  input wire logic                        final_event_o
);

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_index_o)
      && $stable(pressed_o) && $stable(final_event_o))
    else $error("stalled output word changed");

  // A taken scan word keeps the input side busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a scan word");

  // A non-final word on the output means more events are due, so the block is still busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_event_o |-> in_stall_o)
    else $error("input free while events of a word are still due");

  // Key index stays within the key table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> key_index_o < kce_pkg::KeyIdxW'(kce_pkg::MaxKeys))
    else $error("key index out of range");

endmodule

bind key_change_event_emitter_top kce_checker u_kce_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .key_index_o   (key_index_o),
  .pressed_o     (pressed_o),
  .final_event_o (final_event_o)
);

`default_nettype wire

@@ test/key_change_event_emitter_top_test.sv @@
`default_nettype none

module key_change_event_emitter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 400000;
  localparam int SettleCycles  = 16;
  localparam int PhaseCount    = 12;
  localparam int PhaseWords    = 33;
  localparam int PressWords    = 40;
  localparam int HoldoffCycles = 300;
  localparam int MaxGap        = 40;
  localparam int DirRows       = 16;

  typedef struct packed {
    kce_pkg::event_t ev;
    logic            final_event;
  } key_event_t;

  typedef struct packed {
    logic [kce_pkg::ScanW-1:0]   scan;
    logic                        setup;          // load the directed key set first
    logic                        fixed;          // events typed in below
    logic                        fixed_n;        // one typed event, else none
    logic [kce_pkg::KeyIdxW-1:0] fixed_key;
    logic                        fixed_pressed;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [kce_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [kce_pkg::ScanW-1:0]    cfg_data_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [kce_pkg::ScanW-1:0]    scan_word_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [kce_pkg::KeyIdxW-1:0]  key_index_o;
  logic                         pressed_o;
  logic                         final_event_o;

  // Mirror of the block's state and key setup
  logic [kce_pkg::ScanW-1:0]    last_scan;
  logic [kce_pkg::KeyIdxW-1:0]  keys_in_use;
  logic [kce_pkg::ScanW-1:0]    key_masks [kce_pkg::MaxKeys];

  key_event_t          pending_events [$];
  int                  mismatches    = 0;
  int                  stall_pct     = 0;
  logic                holdoff_req   = 1'b0;
  int                  holdoff_left  = 0;
  logic                holdoff_taken = 1'b0;

  dir_row_t dir_rows [DirRows] = '{
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0},  // no keys in use after reset
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 1'b0, 3'd0, 1'b0},  // no change
    '{32'h0001_0000, 1'b0, 1'b1, 1'b1, 3'd0, 1'b1},  // only the all-ones key sees bit 16
    '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 3'd0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0},  // no change
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{32'h0000_0100, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},  // overlapping masks
    '{32'h0000_0300, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{32'h0000_8000, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0}
  };

  key_change_event_emitter_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Queue the events a scan word causes and advance the mirrored scan word
  function automatic int forecast_key_events(input logic [kce_pkg::ScanW-1:0] scan);
    logic [kce_pkg::ScanW-1:0] flipped;
    key_event_t                batch [kce_pkg::MaxKeys];
    int                        n;
    flipped = scan ^ last_scan;
    n = 0;
    for (int k = 0; k < kce_pkg::MaxKeys; k++) begin
      if (k < keys_in_use && (flipped & key_masks[k]) != '0) begin
        batch[n].ev.key_index = kce_pkg::KeyIdxW'(k);
        batch[n].ev.pressed   = |(scan & key_masks[k]);
        batch[n].final_event  = 1'b0;
        n++;
      end
    end
    for (int j = 0; j < n; j++) begin
      if (j == n - 1) batch[j].final_event = 1'b1;
      pending_events.push_back(batch[j]);
    end
    last_scan = scan;
    return n;
  endfunction

  function automatic logic [kce_pkg::ScanW-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return kce_pkg::ScanW'(1) << $urandom_range(0, kce_pkg::ScanW - 1);
      3: return $urandom() & $urandom();
      default: return $urandom();
    endcase
  endfunction

  // Mostly small changes to the last word so that single keys toggle
  function automatic logic [kce_pkg::ScanW-1:0] next_scan();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5:
        return last_scan ^ (kce_pkg::ScanW'(1) << $urandom_range(0, kce_pkg::ScanW - 1));
      6, 7: return last_scan ^ ($urandom() & $urandom() & $urandom());
      8: return last_scan;
      default: return $urandom();
    endcase
  endfunction

  // Offer one word, idling first with the given chance per cycle; return once taken
  task automatic offer_word(input logic [kce_pkg::ScanW-1:0] scan, input int pct);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    scan_word_i <= scan;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_word(input logic [kce_pkg::ScanW-1:0] scan, input int pct);
    offer_word(scan, pct);
    void'(forecast_key_events(scan));
  endtask

  // Drop valid, wait for every expected event, then let words without events clear
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write key count and every mask from the mirrored setup
  task automatic load_key_registers();
    for (int r = 0; r <= kce_pkg::MaxKeys; r++) begin
      cfg_we_i <= 1'b1;
      if (r == 0) begin
        cfg_idx_i  <= kce_pkg::CfgKeyCount;
        cfg_data_i <= kce_pkg::ScanW'(keys_in_use);
      end else begin
        cfg_idx_i  <= kce_pkg::CfgKeyMask0 + kce_pkg::CfgIdxW'(r - 1);
        cfg_data_i <= key_masks[r - 1];
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: event with none expected: key_index=%0d pressed=%0b final_event=%0b",
                 $time, key_index_o, pressed_o, final_event_o);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (key_index_o !== want.ev.key_index) begin
          $display("%0t: key_index mismatch: expected %0d, actual %0d",
                   $time, want.ev.key_index, key_index_o);
          mismatches++;
        end
        if (pressed_o !== want.ev.pressed) begin
          $display("%0t: pressed mismatch: expected %0b, actual %0b",
                   $time, want.ev.pressed, pressed_o);
          mismatches++;
        end
        if (final_event_o !== want.final_event) begin
          $display("%0t: final_event mismatch: expected %0b, actual %0b",
                   $time, want.final_event, final_event_o);
          mismatches++;
        end
      end
    end
  end

  // Receiver: count down a long hold-off once requested, else stall at random
  always @(posedge clk_i) begin
    if (holdoff_req && !holdoff_taken) begin
      holdoff_taken = 1'b1;
      holdoff_left  = HoldoffCycles;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL key_change_event_emitter_top");
    $finish;
  end

  initial begin
    dir_row_t                  row;
    key_event_t                typed;
    logic [kce_pkg::ScanW-1:0] word;
    int                        n;
    int                        send_pct;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = kce_pkg::CfgKeyCount;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    scan_word_i = '0;
    last_scan   = '0;
    keys_in_use = '0;
    foreach (key_masks[k]) key_masks[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.setup) begin
        settle();
        keys_in_use  = 3'd7;
        key_masks[0] = 32'hFFFF_FFFF;
        key_masks[1] = 32'h0000_0001;
        key_masks[2] = 32'h8000_0000;
        key_masks[3] = 32'h0000_0000;  // never fires
        key_masks[4] = 32'h0000_FF00;
        key_masks[5] = 32'h0000_FFFF;
        key_masks[6] = 32'hAAAA_AAAA;
        load_key_registers();
      end
      offer_word(row.scan, 0);
      n = forecast_key_events(row.scan);
      if (row.fixed) begin
        repeat (n) void'(pending_events.pop_back());
        if (row.fixed_n) begin
          typed.ev.key_index = row.fixed_key;
          typed.ev.pressed   = row.fixed_pressed;
          typed.final_event  = 1'b1;
          pending_events.push_back(typed);
        end
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      foreach (key_masks[k]) key_masks[k] = (p == 0) ? '1 : pick_mask();
      if (p == 0) keys_in_use = 3'd7;
      else if (p == 1) keys_in_use = 3'd0;
      else keys_in_use = kce_pkg::KeyIdxW'($urandom_range(1, 7));
      load_key_registers();
      case (p % 4)
        0: begin send_pct = 0;  stall_pct <= 0;  end
        1: begin send_pct = 81; stall_pct <= 0;  end
        2: begin send_pct = 0;  stall_pct <= 81; end
        default: begin send_pct = 13; stall_pct <= 13; end
      endcase
      repeat (PhaseWords) begin
        word = next_scan();
        send_word(word, send_pct);
      end
    end

    // Hold the output off while words keep coming, so the input backs up
    settle();
    keys_in_use = 3'd7;
    foreach (key_masks[k]) begin
      key_masks[k] = pick_mask() | (kce_pkg::ScanW'(1) << $urandom_range(0, 31));
    end
    load_key_registers();
    stall_pct   <= 0;
    holdoff_req <= 1'b1;
    repeat (PressWords) send_word($urandom(), 0);

    settle();
    if (mismatches == 0) begin
      $display("PASS key_change_event_emitter_top");
    end else begin
      $display("FAIL key_change_event_emitter_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
